### sv/gas_sensor_frame_decoder_unit_macros.svh
// ----------------------------------------------------------------------------
// gas sensor frame decoder assertion macros
// concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef GAS_SENSOR_FRAME_DECODER_UNIT_MACROS_SVH
`define GAS_SENSOR_FRAME_DECODER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GSFD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gsfd assertion failed");
`define GSFD_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) pre |=> post) \
      else $error("gsfd sequence assertion failed");
`else
`define GSFD_ASSERT(label, clk, rst, prop)
`define GSFD_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

### sv/gsfd_pkg.sv
// ----------------------------------------------------------------------------
// gsfd_pkg
// shared types and constants of the gas sensor frame decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gsfd_pkg;

   localparam int FRAME_LENGTH  = 13;
   localparam int PAYLOAD_FIRST = 6;
   localparam int PAYLOAD_BYTES = 6;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [7:0] HDR0 = 8'hFF;
   localparam logic [7:0] HDR1 = 8'h87;

   localparam logic signed [33:0] ONE_Q24 = 34'sd16777216;
   localparam logic [24:0]        GAS_MAX = 25'h1FF_FFFF;

   // register reset values, two's complement where signed
   localparam logic [15:0] TEMP_LOW_RESET   = 16'hF060;
   localparam logic [15:0] TEMP_HIGH_RESET  = 16'd8500;
   localparam logic [15:0] HUMID_HIGH_RESET = 16'd10000;
   localparam logic [15:0] TEMP_BASE_RESET  = 16'd2600;
   localparam logic [15:0] HUMID_BASE_RESET = 16'd5500;
   localparam logic [15:0] TEMP_COEF_RESET  = 16'd503;
   localparam logic [15:0] HUMID_COEF_RESET = 16'd252;

   typedef enum logic [1:0] {
      REQ_BYTE    = 2'd0,
      REQ_RESTART = 2'd1,
      REQ_TIMEOUT = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_TIMEOUT    = 3'd1,
      ST_BAD_HEADER = 3'd2,
      ST_CHECKSUM   = 3'd3,
      ST_RANGE      = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CSR_TEMP_LOW   = 3'd0,
      CSR_TEMP_HIGH  = 3'd1,
      CSR_HUMID_HIGH = 3'd2,
      CSR_TEMP_BASE  = 3'd3,
      CSR_HUMID_BASE = 3'd4,
      CSR_TEMP_COEF  = 3'd5,
      CSR_HUMID_COEF = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [15:0] temp_low;
      logic [15:0] temp_high;
      logic [15:0] humid_high;
      logic [15:0] temp_base;
      logic [15:0] humid_base;
      logic [15:0] temp_coef;
      logic [15:0] humid_coef;
   } cfg_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] gas;
      logic [15:0] temp;
      logic [15:0] humid;
   } job_type;

   typedef enum logic [2:0] {
      B_IDLE = 3'd0,
      B_TFAC = 3'd1,
      B_HFAC = 3'd2,
      B_GAS  = 3'd3,
      B_LOW  = 3'd4,
      B_HIGH = 3'd5,
      B_SAT  = 3'd6
   } back_state_type;

endpackage

### sv/gsfd_queue.sv
// ----------------------------------------------------------------------------
// gsfd_queue
// small job queue between frame front end and compensation back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gas_sensor_frame_decoder_unit_macros.svh"

module gsfd_queue #(
   parameter int DEPTH = gsfd_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gsfd_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output gsfd_pkg::job_type head_job
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   gsfd_pkg::job_type entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   `GSFD_ASSERT(a_no_overflow, clock, reset, !(push && full))
   `GSFD_ASSERT(a_no_underflow, clock, reset, !(pop && !head_valid))
   `GSFD_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH))

endmodule

### sv/gsfd_front.sv
// ----------------------------------------------------------------------------
// gsfd_front
// frame assembly, header, checksum and range classification
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gsfd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_type,
   input  logic [7:0]        req_rx_byte,
   input  gsfd_pkg::cfg_type cfg,
   input  logic              q_full,
   output logic              push,
   output gsfd_pkg::job_type push_job
);

   localparam logic [3:0] LAST_POS  = 4'(gsfd_pkg::FRAME_LENGTH - 1);
   localparam logic [3:0] FIRST_PAY = 4'(gsfd_pkg::PAYLOAD_FIRST);

   logic [3:0] pos_ff, pos_in;
   logic [7:0] sum_ff, sum_in;
   logic       hdr_ff, hdr_in;
   logic [7:0] payload_ff [gsfd_pkg::PAYLOAD_BYTES];
   logic       pay_we;
   logic [2:0] pay_idx;
   logic       accept;
   logic [15:0] gas, temp, humid;
   logic       range_bad;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;
   assign pay_idx   = 3'(pos_ff - FIRST_PAY);

   assign gas   = {payload_ff[0], payload_ff[1]};
   assign temp  = {payload_ff[2], payload_ff[3]};
   assign humid = {payload_ff[4], payload_ff[5]};

   assign range_bad = ($signed(temp) < $signed(cfg.temp_low))
                   || ($signed(temp) > $signed(cfg.temp_high))
                   || (humid > cfg.humid_high);

   always_comb begin
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      hdr_in   = hdr_ff;
      pay_we   = 1'b0;
      push     = 1'b0;
      push_job = '{status: gsfd_pkg::ST_OK, gas: gas, temp: '0, humid: '0};
      if (accept) begin
         case (req_type)
            gsfd_pkg::REQ_BYTE: begin
               if (pos_ff == '0) begin
                  sum_in = '0;
                  hdr_in = (req_rx_byte == gsfd_pkg::HDR0);
                  pos_in = 4'd1;
               end else if (pos_ff != LAST_POS) begin
                  if (pos_ff == 4'd1 && req_rx_byte != gsfd_pkg::HDR1) begin
                     hdr_in = 1'b0;
                  end
                  sum_in = sum_ff + req_rx_byte;
                  pay_we = (pos_ff >= FIRST_PAY);
                  pos_in = pos_ff + 1'b1;
               end else begin
                  push   = 1'b1;
                  pos_in = '0;
                  sum_in = '0;
                  hdr_in = 1'b1;
                  if (!hdr_ff) begin
                     push_job.status = gsfd_pkg::ST_BAD_HEADER;
                  end else if ((8'h00 - sum_ff) != req_rx_byte) begin
                     push_job.status = gsfd_pkg::ST_CHECKSUM;
                  end else if (range_bad) begin
                     push_job.status = gsfd_pkg::ST_RANGE;
                     push_job.temp   = temp;
                     push_job.humid  = humid;
                  end else begin
                     push_job.temp   = temp;
                     push_job.humid  = humid;
                  end
               end
            end
            gsfd_pkg::REQ_RESTART: begin
               pos_in = '0;
               sum_in = '0;
               hdr_in = 1'b1;
            end
            gsfd_pkg::REQ_TIMEOUT: begin
               pos_in          = '0;
               sum_in          = '0;
               hdr_in          = 1'b1;
               push            = 1'b1;
               push_job.status = gsfd_pkg::ST_TIMEOUT;
               push_job.gas    = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         sum_ff <= '0;
         hdr_ff <= 1'b1;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
         hdr_ff <= hdr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pay_we) begin
         payload_ff[pay_idx] <= req_rx_byte;
      end
   end

endmodule

### sv/gsfd_back.sv
// ----------------------------------------------------------------------------
// gsfd_back
// temperature and humidity gas compensation sequencer with output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gas_sensor_frame_decoder_unit_macros.svh"

module gsfd_back (
   input  logic                clock,
   input  logic                reset,
   input  gsfd_pkg::cfg_type   cfg,
   input  logic                q_valid,
   input  gsfd_pkg::job_type   q_head,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_status,
   output logic [24:0]         rsp_gas_comp_q8,
   output logic signed [15:0]  rsp_temp_hundredths,
   output logic [15:0]         rsp_humid_hundredths
);

   gsfd_pkg::back_state_type state_ff, state_in;
   gsfd_pkg::job_type        job_ff, job_in;

   logic [32:0] ft_ff, ft_in;
   logic [32:0] fh_ff, fh_in;
   logic [32:0] g1_ff, g1_in;
   logic [65:0] acc_ff, acc_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [24:0] rsp_gas_ff, rsp_gas_in;
   logic [15:0] rsp_temp_ff, rsp_temp_in;
   logic [15:0] rsp_humid_ff, rsp_humid_in;

   logic               slot_free;
   logic signed [16:0] tdiff, hdiff;
   logic signed [16:0] mul_a, mul_b;
   logic signed [33:0] fac_prod, fac_sum;
   logic [32:0]        fac_clamp;
   logic [48:0]        gas_prod;
   logic [49:0]        lo_prod;
   logic [48:0]        hi_prod;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign tdiff = 17'($signed(job_ff.temp)) - 17'($signed(cfg.temp_base));
   assign hdiff = $signed({1'b0, job_ff.humid}) - $signed({1'b0, cfg.humid_base});

   // one multiplier shared by both factors
   assign mul_a = (state_ff == gsfd_pkg::B_TFAC) ? $signed({1'b0, cfg.temp_coef})
                                                 : $signed({1'b0, cfg.humid_coef});
   assign mul_b     = (state_ff == gsfd_pkg::B_TFAC) ? tdiff : hdiff;
   assign fac_prod  = 34'(mul_a) * 34'(mul_b);
   assign fac_sum   = gsfd_pkg::ONE_Q24 + fac_prod;
   assign fac_clamp = fac_sum[33] ? '0 : fac_sum[32:0];

   assign gas_prod = 49'(job_ff.gas) * 49'(ft_ff);
   assign lo_prod  = 50'(g1_ff) * 50'(fh_ff[16:0]);
   assign hi_prod  = 49'(g1_ff) * 49'(fh_ff[32:17]);

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      ft_in         = ft_ff;
      fh_in         = fh_ff;
      g1_in         = g1_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_gas_in    = rsp_gas_ff;
      rsp_temp_in   = rsp_temp_ff;
      rsp_humid_in  = rsp_humid_ff;
      q_pop         = 1'b0;
      case (state_ff)
         gsfd_pkg::B_IDLE: begin
            if (q_valid && slot_free) begin
               q_pop  = 1'b1;
               job_in = q_head;
               if (q_head.status == gsfd_pkg::ST_OK) begin
                  state_in = gsfd_pkg::B_TFAC;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = q_head.status;
                  rsp_gas_in    = '0;
                  rsp_temp_in   = q_head.temp;
                  rsp_humid_in  = q_head.humid;
               end
            end
         end
         gsfd_pkg::B_TFAC: begin
            ft_in    = fac_clamp;
            state_in = gsfd_pkg::B_HFAC;
         end
         gsfd_pkg::B_HFAC: begin
            fh_in    = fac_clamp;
            state_in = gsfd_pkg::B_GAS;
         end
         gsfd_pkg::B_GAS: begin
            g1_in    = gas_prod[48:16];
            state_in = gsfd_pkg::B_LOW;
         end
         gsfd_pkg::B_LOW: begin
            acc_in   = 66'(lo_prod);
            state_in = gsfd_pkg::B_HIGH;
         end
         gsfd_pkg::B_HIGH: begin
            acc_in   = acc_ff + {hi_prod, 17'b0};
            state_in = gsfd_pkg::B_SAT;
         end
         gsfd_pkg::B_SAT: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = job_ff.status;
            rsp_gas_in    = (|acc_ff[65:49]) ? gsfd_pkg::GAS_MAX : acc_ff[48:24];
            rsp_temp_in   = job_ff.temp;
            rsp_humid_in  = job_ff.humid;
            state_in      = gsfd_pkg::B_IDLE;
         end
         default: begin
            state_in = gsfd_pkg::B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gsfd_pkg::B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      ft_ff         <= ft_in;
      fh_ff         <= fh_in;
      g1_ff         <= g1_in;
      acc_ff        <= acc_in;
      rsp_status_ff <= rsp_status_in;
      rsp_gas_ff    <= rsp_gas_in;
      rsp_temp_ff   <= rsp_temp_in;
      rsp_humid_ff  <= rsp_humid_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_gas_comp_q8      = rsp_gas_ff;
   assign rsp_temp_hundredths  = $signed(rsp_temp_ff);
   assign rsp_humid_hundredths = rsp_humid_ff;

   `GSFD_ASSERT(a_busy_out_empty, clock, reset, (state_ff != gsfd_pkg::B_IDLE) |-> !rsp_valid_ff)
   `GSFD_ASSERT_NEXT(a_ok_starts, clock, reset, q_pop && (q_head.status == gsfd_pkg::ST_OK), state_ff == gsfd_pkg::B_TFAC)
   `GSFD_ASSERT(a_err_no_gas, clock, reset, (rsp_valid_ff && rsp_status_ff != gsfd_pkg::ST_OK) |-> (rsp_gas_ff == '0))
   `GSFD_ASSERT(a_timeout_zero, clock, reset, (rsp_valid_ff && rsp_status_ff == gsfd_pkg::ST_TIMEOUT) |-> (rsp_temp_ff == '0 && rsp_humid_ff == '0))

endmodule

### sv/gas_sensor_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// gas_sensor_frame_decoder_unit
// sensor frame decoder with checksum, range check and gas compensation
// ----------------------------------------------------------------------------
// usage
//   req channel: one transaction per received byte, restart or reply timeout;
//   req_stall rises only while the internal job queue is full
//   rsp channel: one transaction per completed frame or timeout with status,
//   compensated gas in Q8 ppb and raw temperature and humidity
//   csr channel: always ready; the user must make register writes only
//   while the unit is idle, which the unit itself does not enforce
// result path from the transaction that completes a frame: error or
//   timeout: queue entry, then output register; good frame: queue entry,
//   shared factor multiplier, gas product, the two halves of the humidity
//   product, then output register; one byte per cycle while req_stall is low;
//   back end: one good frame at a time, one error result per cycle unstalled
// reset: frame position cleared, queue and output emptied, registers loaded
//   with their default limits, baselines and coefficients
// rsp_stall holds the result in the output register; the queue keeps taking
//   jobs until it fills, then req_stall rises
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gas_sensor_frame_decoder_unit #(
   parameter int QUEUE_DEPTH = gsfd_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic [24:0]        rsp_gas_comp_q8,
   output logic signed [15:0] rsp_temp_hundredths,
   output logic [15:0]        rsp_humid_hundredths,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   gsfd_pkg::cfg_type cfg_ff, cfg_in;
   gsfd_pkg::job_type push_job, head_job;
   logic              push, q_full, pop, head_valid;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            gsfd_pkg::CSR_TEMP_LOW:   cfg_in.temp_low   = csr_wdata;
            gsfd_pkg::CSR_TEMP_HIGH:  cfg_in.temp_high  = csr_wdata;
            gsfd_pkg::CSR_HUMID_HIGH: cfg_in.humid_high = csr_wdata;
            gsfd_pkg::CSR_TEMP_BASE:  cfg_in.temp_base  = csr_wdata;
            gsfd_pkg::CSR_HUMID_BASE: cfg_in.humid_base = csr_wdata;
            gsfd_pkg::CSR_TEMP_COEF:  cfg_in.temp_coef  = csr_wdata;
            gsfd_pkg::CSR_HUMID_COEF: cfg_in.humid_coef = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{temp_low:   gsfd_pkg::TEMP_LOW_RESET,
                     temp_high:  gsfd_pkg::TEMP_HIGH_RESET,
                     humid_high: gsfd_pkg::HUMID_HIGH_RESET,
                     temp_base:  gsfd_pkg::TEMP_BASE_RESET,
                     humid_base: gsfd_pkg::HUMID_BASE_RESET,
                     temp_coef:  gsfd_pkg::TEMP_COEF_RESET,
                     humid_coef: gsfd_pkg::HUMID_COEF_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gsfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_type    (req_type),
      .req_rx_byte (req_rx_byte),
      .cfg         (cfg_ff),
      .q_full      (q_full),
      .push        (push),
      .push_job    (push_job)
   );

   gsfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   gsfd_back u_back (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .q_valid              (head_valid),
      .q_head               (head_job),
      .q_pop                (pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_gas_comp_q8      (rsp_gas_comp_q8),
      .rsp_temp_hundredths  (rsp_temp_hundredths),
      .rsp_humid_hundredths (rsp_humid_hundredths)
   );

endmodule

### sim/gas_sensor_frame_decoder_unit_tb.sv
// ----------------------------------------------------------------------------
// gas_sensor_frame_decoder_unit_tb
// self-checking bench: drives bytes, restarts and timeouts into the decoder,
// predicts each status result with a local frame decoder and compensation
// model, and checks every rsp transaction field by field under random idling,
// output backpressure and several register settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gas_sensor_frame_decoder_unit_tb;

   import gsfd_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int DRAIN_SETTLE = 16;
   localparam int FINAL_WAIT_LIMIT = 20000;

   typedef logic [7:0] frame_bytes_t [FRAME_LENGTH];

   typedef struct packed {
      status_type  status;
      logic [24:0] gas;
      logic [15:0] temp;
      logic [15:0] humid;
   } decoded_frame_t;

   typedef enum int {
      SHAPE_GOOD,
      SHAPE_BAD_LEAD,
      SHAPE_BAD_ID,
      SHAPE_BAD_ID_AND_SUM,
      SHAPE_BAD_SUM,
      SHAPE_BAD_SUM_AND_RANGE,
      SHAPE_TEMP_LOW,
      SHAPE_TEMP_HIGH,
      SHAPE_HUMID_HIGH,
      SHAPE_CUT_RESTART,
      SHAPE_CUT_TIMEOUT,
      SHAPE_STRAY,
      SHAPE_NOISE
   } frame_shape_t;

   localparam int SHAPE_COUNT = 13;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_type = 2'd0;
   logic [7:0]         req_rx_byte = 8'd0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [2:0]         rsp_status;
   logic [24:0]        rsp_gas_comp_q8;
   logic signed [15:0] rsp_temp_hundredths;
   logic [15:0]        rsp_humid_hundredths;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = 3'd0;
   logic [15:0]        csr_wdata = 16'd0;

   // local copy of the decoder registers and frame state
   logic signed [15:0] temp_lo = TEMP_LOW_RESET;
   logic signed [15:0] temp_hi = TEMP_HIGH_RESET;
   logic [15:0]        humid_hi = HUMID_HIGH_RESET;
   logic signed [15:0] temp_base = TEMP_BASE_RESET;
   logic [15:0]        humid_base = HUMID_BASE_RESET;
   logic [15:0]        temp_coef = TEMP_COEF_RESET;
   logic [15:0]        humid_coef = HUMID_COEF_RESET;

   int          frame_pos = 0;
   logic [7:0]  frame_sum = 8'd0;
   bit          header_ok = 1'b1;
   logic [7:0]  payload [PAYLOAD_BYTES] = '{default: 8'd0};

   decoded_frame_t expected_frames[$];
   int  error_count = 0;
   bit  req_quiet = 1'b0;
   bit  rsp_quiet = 1'b0;
   int  hold_request = 0;

   gas_sensor_frame_decoder_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_type),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_gas_comp_q8     (rsp_gas_comp_q8),
      .rsp_temp_hundredths (rsp_temp_hundredths),
      .rsp_humid_hundredths(rsp_humid_hundredths),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #2 clock = ~clock;

   task automatic report_error(input string msg);
      $display("mismatch at %0t ns: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic void drop_frame();
      frame_pos = 0;
      frame_sum = 8'd0;
      header_ok = 1'b1;
   endfunction

   function automatic logic [24:0] predict_gas(input logic [15:0] gas,
                                               input logic signed [15:0] temp,
                                               input logic [15:0] humid);
      longint      ft;
      longint      fh;
      logic [127:0] g1;
      logic [127:0] prod;
      ft = longint'(ONE_Q24) + longint'(temp_coef) * (longint'(temp) - longint'(temp_base));
      fh = longint'(ONE_Q24) + longint'(humid_coef) * (longint'(humid) - longint'(humid_base));
      if (ft < 0) ft = 0;
      if (fh < 0) fh = 0;
      g1 = (128'(gas) * 128'(ft)) >> 16;
      prod = (g1 * 128'(fh)) >> 24;
      if (prod > 128'(GAS_MAX)) return GAS_MAX;
      return prod[24:0];
   endfunction

   function automatic void decode_transaction(input logic [1:0] kind, input logic [7:0] data);
      decoded_frame_t     r;
      logic [15:0]        gas;
      logic signed [15:0] temp;
      logic [15:0]        humid;
      r = '0;
      if (kind == REQ_RESTART) begin
         drop_frame();
      end else if (kind == REQ_TIMEOUT) begin
         drop_frame();
         r.status = ST_TIMEOUT;
         expected_frames.push_back(r);
      end else if (kind == REQ_BYTE) begin
         if (frame_pos == 0) begin
            frame_sum = 8'd0;
            header_ok = (data == HDR0);
         end else if (frame_pos < FRAME_LENGTH - 1) begin
            if (frame_pos == 1 && data != HDR1) header_ok = 1'b0;
            frame_sum = frame_sum + data;
            if (frame_pos >= PAYLOAD_FIRST) payload[frame_pos - PAYLOAD_FIRST] = data;
         end
         if (frame_pos < FRAME_LENGTH - 1) begin
            frame_pos++;
         end else begin
            gas = {payload[0], payload[1]};
            temp = {payload[2], payload[3]};
            humid = {payload[4], payload[5]};
            if (!header_ok) begin
               r.status = ST_BAD_HEADER;
            end else if (8'(8'h00 - frame_sum) != data) begin
               r.status = ST_CHECKSUM;
            end else if (temp < temp_lo || temp > temp_hi || humid > humid_hi) begin
               r.status = ST_RANGE;
            end else begin
               r.status = ST_OK;
               r.gas = predict_gas(gas, temp, humid);
            end
            if (r.status != ST_BAD_HEADER && r.status != ST_CHECKSUM) begin
               r.temp = temp;
               r.humid = humid;
            end
            drop_frame();
            expected_frames.push_back(r);
         end
      end
   endfunction

   // one req transaction, then the sender gap
   task automatic send_item(input logic [1:0] kind, input logic [7:0] data);
      int gap;
      req_valid <= 1'b1;
      req_type <= kind;
      req_rx_byte <= data;
      do @(posedge clock); while (req_stall);
      decode_transaction(kind, data);
      gap = req_quiet ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_SETTLE) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_TEMP_LOW:   temp_lo = value;
         CSR_TEMP_HIGH:  temp_hi = value;
         CSR_HUMID_HIGH: humid_hi = value;
         CSR_TEMP_BASE:  temp_base = value;
         CSR_HUMID_BASE: humid_base = value;
         CSR_TEMP_COEF:  temp_coef = value;
         CSR_HUMID_COEF: humid_coef = value;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input int tlo, input int thi, input int hhi, input int tbase,
                                 input int hbase, input int tcoef, input int hcoef);
      wait_idle();
      write_register(CSR_TEMP_LOW, 16'(tlo));
      write_register(CSR_TEMP_HIGH, 16'(thi));
      write_register(CSR_HUMID_HIGH, 16'(hhi));
      write_register(CSR_TEMP_BASE, 16'(tbase));
      write_register(CSR_HUMID_BASE, 16'(hbase));
      write_register(CSR_TEMP_COEF, 16'(tcoef));
      write_register(CSR_HUMID_COEF, 16'(hcoef));
      csr_valid <= 1'b0;
   endtask

   function automatic int pick_between(input int lo, input int hi);
      if (hi < lo) return lo;
      case ($urandom_range(0, 7))
         0: return lo;
         1: return hi;
         default: return lo + int'($urandom_range(0, hi - lo));
      endcase
   endfunction

   function automatic logic [7:0] frame_checksum(input frame_bytes_t f);
      logic [7:0] s;
      s = 8'd0;
      for (int i = 1; i < FRAME_LENGTH - 1; i++) s = s + f[i];
      return 8'(8'h00 - s);
   endfunction

   task automatic send_bytes(input frame_bytes_t f, input int count, input int stray_at);
      for (int i = 0; i < count; i++) begin
         if (i == stray_at) send_item(REQ_UNUSED, 8'($urandom));
         send_item(REQ_BYTE, f[i]);
      end
   endtask

   task automatic send_frame(input frame_shape_t shape);
      frame_bytes_t f;
      int           t_val;
      int           h_val;
      int           tlo;
      int           thi;
      int           hhi;
      int           cut;
      int           stray_at;
      logic [15:0]  gas;
      logic [15:0]  t16;
      logic [15:0]  h16;
      tlo = temp_lo;
      thi = temp_hi;
      hhi = humid_hi;
      case ($urandom_range(0, 7))
         0: gas = 16'h0000;
         1: gas = 16'hFFFF;
         default: gas = 16'($urandom);
      endcase
      t_val = pick_between(tlo, thi);
      h_val = pick_between(0, hhi);
      case (shape)
         SHAPE_TEMP_LOW, SHAPE_BAD_SUM_AND_RANGE: begin
            if (tlo > -32768) t_val = pick_between(-32768, tlo - 1);
         end
         SHAPE_TEMP_HIGH: begin
            if (thi < 32767) t_val = pick_between(thi + 1, 32767);
         end
         SHAPE_HUMID_HIGH: begin
            if (hhi < 65535) h_val = pick_between(hhi + 1, 65535);
         end
         default: ;
      endcase
      t16 = t_val[15:0];
      h16 = h_val[15:0];
      f[0] = HDR0;
      f[1] = HDR1;
      for (int i = 2; i < PAYLOAD_FIRST; i++) f[i] = 8'($urandom);
      f[6] = gas[15:8];
      f[7] = gas[7:0];
      f[8] = t16[15:8];
      f[9] = t16[7:0];
      f[10] = h16[15:8];
      f[11] = h16[7:0];
      if (shape == SHAPE_BAD_LEAD) f[0] = 8'($urandom_range(0, 254));
      if (shape == SHAPE_BAD_ID || shape == SHAPE_BAD_ID_AND_SUM)
         f[1] = f[1] ^ 8'($urandom_range(1, 255));
      f[12] = frame_checksum(f);
      if (shape == SHAPE_BAD_ID_AND_SUM || shape == SHAPE_BAD_SUM ||
          shape == SHAPE_BAD_SUM_AND_RANGE)
         f[12] = f[12] ^ 8'($urandom_range(1, 255));
      if (shape == SHAPE_NOISE)
         for (int i = 0; i < FRAME_LENGTH; i++) f[i] = 8'($urandom);
      cut = FRAME_LENGTH;
      stray_at = -1;
      if (shape == SHAPE_CUT_RESTART || shape == SHAPE_CUT_TIMEOUT)
         cut = $urandom_range(1, FRAME_LENGTH - 1);
      if (shape == SHAPE_STRAY) stray_at = $urandom_range(1, FRAME_LENGTH - 1);
      send_bytes(f, cut, stray_at);
      if (shape == SHAPE_CUT_RESTART) send_item(REQ_RESTART, 8'($urandom));
      if (shape == SHAPE_CUT_TIMEOUT) send_item(REQ_TIMEOUT, 8'($urandom));
   endtask

   task automatic run_random_frames(input int frames);
      int r;
      for (int n = 0; n < frames; n++) begin
         req_quiet = ($urandom_range(0, 4) == 0);
         rsp_quiet = ($urandom_range(0, 4) == 0);
         r = $urandom_range(0, 2 * SHAPE_COUNT - 1);
         send_frame(r < SHAPE_COUNT ? frame_shape_t'(r) : SHAPE_GOOD);
         case ($urandom_range(0, 11))
            0: send_item(REQ_TIMEOUT, 8'($urandom));
            1: send_item(REQ_RESTART, 8'($urandom));
            2: send_item(REQ_UNUSED, 8'($urandom));
            default: ;
         endcase
      end
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
   endtask

   task automatic test_basic_requests();
      frame_bytes_t f;
      send_item(REQ_TIMEOUT, 8'h00);
      send_item(REQ_UNUSED, 8'hFF);
      send_item(REQ_RESTART, 8'hA5);
      send_item(REQ_BYTE, HDR0);
      send_item(REQ_BYTE, HDR1);
      send_item(REQ_BYTE, 8'h00);
      send_item(REQ_RESTART, 8'h5A);
      send_item(REQ_BYTE, HDR0);
      send_item(REQ_TIMEOUT, 8'hFF);
      // full scale gas at both baselines
      f = '{HDR0, HDR1, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF,
            8'h0A, 8'h28, 8'h15, 8'h7C, 8'h00};
      f[12] = frame_checksum(f);
      send_bytes(f, FRAME_LENGTH, -1);
   endtask

   task automatic test_frame_shapes();
      for (int s = 0; s < SHAPE_COUNT; s++) send_frame(frame_shape_t'(s));
   endtask

   task automatic test_settings_sweep();
      int tlo;
      int thi;
      int swap;
      run_random_frames(6);
      // large gains, saturation
      apply_settings(-32768, 32767, 65535, -32768, 0, 65535, 65535);
      run_random_frames(5);
      // baselines at the top, factors clamp at zero
      apply_settings(-32768, 32767, 65535, 32767, 65535, 65535, 65535);
      run_random_frames(4);
      // single accepted point, unity factors
      apply_settings(0, 0, 0, 0, 0, 0, 0);
      run_random_frames(4);
      repeat (2) begin
         tlo = $urandom_range(0, 65535) - 32768;
         thi = $urandom_range(0, 65535) - 32768;
         if (thi < tlo) begin
            swap = tlo;
            tlo = thi;
            thi = swap;
         end
         apply_settings(tlo, thi, $urandom_range(0, 65535), $urandom_range(0, 65535) - 32768,
                        $urandom_range(0, 65535), $urandom_range(0, 2047),
                        $urandom_range(0, 2047));
         run_random_frames(4);
      end
      apply_settings(-4000, 8500, 10000, 2600, 5500, 503, 252);
   endtask

   task automatic test_full_rate();
      req_quiet = 1'b1;
      rsp_quiet = 1'b1;
      send_frame(SHAPE_GOOD);
      send_frame(SHAPE_BAD_SUM);
      send_item(REQ_TIMEOUT, 8'($urandom));
      send_frame(SHAPE_GOOD);
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
   endtask

   task automatic test_output_backpressure();
      wait_idle();
      hold_request = 300;
      req_quiet = 1'b1;
      repeat (3) begin
         send_frame(SHAPE_GOOD);
         send_item(REQ_TIMEOUT, 8'($urandom));
      end
      send_frame(SHAPE_TEMP_HIGH);
      req_quiet = 1'b0;
      wait_idle();
   endtask

   task automatic finish_run();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (expected_frames.size() != 0 && waited < FINAL_WAIT_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_SETTLE) @(posedge clock);
      while (expected_frames.size() != 0) begin
         report_error($sformatf("result never arrived, status %0d",
                                expected_frames[0].status));
         void'(expected_frames.pop_front());
      end
      if (error_count == 0) begin
         $display("** gas_sensor_frame_decoder_unit: PASSED **");
      end else begin
         $display("** gas_sensor_frame_decoder_unit: FAILED **");
      end
      $finish;
   endtask

   // result side: per-transaction stall draw plus an optional long hold
   initial begin : result_checker
      decoded_frame_t want;
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_frames.size() == 0) begin
               report_error($sformatf("unexpected result, status %0d", rsp_status));
            end else begin
               want = expected_frames.pop_front();
               if (rsp_status !== want.status)
                  report_error($sformatf("status got %0d expected %0d",
                                         rsp_status, want.status));
               if (rsp_gas_comp_q8 !== want.gas)
                  report_error($sformatf("gas got %0d expected %0d",
                                         rsp_gas_comp_q8, want.gas));
               if (rsp_temp_hundredths !== want.temp)
                  report_error($sformatf("temp got %0d expected %0d",
                                         rsp_temp_hundredths, $signed(want.temp)));
               if (rsp_humid_hundredths !== want.humid)
                  report_error($sformatf("humid got %0d expected %0d",
                                         rsp_humid_hundredths, want.humid));
            end
            stall_left = rsp_quiet ? 0 : $urandom_range(0, 7);
         end
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #2_000_000;
      $display("** gas_sensor_frame_decoder_unit: FAILED **");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_basic_requests();
      test_frame_shapes();
      test_settings_sweep();
      test_full_rate();
      test_output_backpressure();
      finish_run();
   end

endmodule
